// File: src/ptach_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ptach_pkg;

    localparam int unsigned DistWidth = 9;
    localparam int unsigned TimeWidth = 16;
    localparam int unsigned RpmWidth  = 16;
    localparam int unsigned CountWidth = $clog2(TimeWidth);

    localparam logic [DistWidth-1:0]  THRESHOLD_RESET = 9'd10;
    localparam logic [RpmWidth-1:0]   MS_PER_MINUTE   = 16'd60000;
    localparam logic [CountWidth-1:0] DIV_LAST_STEP   = CountWidth'(TimeWidth - 1);

    // Control sequencer of the block.
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DIV  = 2'd1,
        ST_LOAD = 2'd2
    } state_t;

    // Measurement phase, advanced at most once per accepted sample.
    typedef enum logic [1:0] {
        PH_IDLE       = 2'd0,
        PH_START_NEAR = 2'd1,
        PH_ARMED      = 2'd2,
        PH_END_NEAR   = 2'd3
    } phase_t;

endpackage

`default_nettype wire

// File: src/proximity_tachometer_rpm.sv
`timescale 1ns / 1ps
`default_nettype none

// Revolution period and rpm from a stream of timestamped distance samples.
// Input channel (s_valid/s_ready): one beat carries a distance in cm and a
// 16-bit millisecond timestamp. A distance at or below the threshold means the
// marker is near. The block captures the start time on the first not-near
// sample after a near run, and the end time on the first not-near sample after
// the next near run. Result channel (m_valid/m_ready): one beat per completed
// measurement with the wrapping period and 60000 / period (0 for period 0).
// Configuration channel (cfg_valid/cfg_ready): writes the 9-bit threshold; it
// is always ready and must only be used while the block is idle.
// A sample that does not complete a measurement leaves the input channel ready.
// A completing sample starts a restoring divider that produces one quotient
// bit per cycle, so the input channel is closed during the 16 divide steps
// and the load state; m_valid rises when the load state writes the result.
// The result sits in an output register; while it waits for m_ready, further
// non-completing samples are still accepted. Only a second completed divide
// stalls in the load state until the output register is free.
// Reset (aresetn low, synchronous) restores the threshold to 10, returns the
// phase to idle, clears the start time and drops m_valid.

module proximity_tachometer_rpm (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [8:0]  cfg_distance_threshold,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [8:0]  s_distance_cm,
    input  wire logic [15:0] s_time_ms,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_period_ms,
    output logic [15:0]      m_rpm
);

    ptach_pkg::state_t state_reg, state_next;
    ptach_pkg::phase_t phase_reg, phase_next;

    logic [8:0]  thr_reg, thr_next;
    logic [15:0] start_reg, start_next;
    logic [15:0] div_reg, div_next;     // divisor, equal to the period
    logic [15:0] rem_reg, rem_next;     // partial remainder
    logic [15:0] quo_reg, quo_next;     // dividend bits out, quotient bits in
    logic [ptach_pkg::CountWidth-1:0] cnt_reg, cnt_next;
    logic        m_valid_reg, m_valid_next;
    logic [15:0] m_period_reg, m_period_next;
    logic [15:0] m_rpm_reg, m_rpm_next;

    logic        s_beat;
    logic        near;
    logic [16:0] rem_shift;
    logic        ge;
    logic        out_free;

    assign cfg_ready   = 1'b1;
    assign s_ready     = (state_reg == ptach_pkg::ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_period_ms = m_period_reg;
    assign m_rpm       = m_rpm_reg;

    assign s_beat   = s_valid && s_ready;
    assign near     = (s_distance_cm <= thr_reg);
    assign out_free = !m_valid_reg || m_ready;

    // One restoring divide step: bring down the next dividend bit and subtract
    // the divisor when it fits. The remainder stays below the divisor, so 17
    // bits hold the shifted value.
    assign rem_shift = {rem_reg, quo_reg[15]};
    assign ge        = (rem_shift >= {1'b0, div_reg});

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        thr_next      = thr_reg;
        start_next    = start_reg;
        div_next      = div_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        cnt_next      = cnt_reg;
        m_valid_next  = m_valid_reg;
        m_period_next = m_period_reg;
        m_rpm_next    = m_rpm_reg;

        if (cfg_valid) begin
            thr_next = cfg_distance_threshold;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ptach_pkg::ST_IDLE: begin
                if (s_beat) begin
                    case (phase_reg)
                        ptach_pkg::PH_IDLE: begin
                            if (near) begin
                                phase_next = ptach_pkg::PH_START_NEAR;
                            end
                        end
                        ptach_pkg::PH_START_NEAR: begin
                            if (!near) begin
                                start_next = s_time_ms;
                                phase_next = ptach_pkg::PH_ARMED;
                            end
                        end
                        ptach_pkg::PH_ARMED: begin
                            if (near) begin
                                phase_next = ptach_pkg::PH_END_NEAR;
                            end
                        end
                        ptach_pkg::PH_END_NEAR: begin
                            if (!near) begin
                                // Measurement complete: launch the divider.
                                phase_next = ptach_pkg::PH_IDLE;
                                div_next   = s_time_ms - start_reg;
                                rem_next   = '0;
                                quo_next   = ptach_pkg::MS_PER_MINUTE;
                                cnt_next   = '0;
                                state_next = ptach_pkg::ST_DIV;
                            end
                        end
                        default: begin
                            phase_next = ptach_pkg::PH_IDLE;
                        end
                    endcase
                end
            end
            ptach_pkg::ST_DIV: begin
                rem_next = ge ? 16'(rem_shift - {1'b0, div_reg}) : rem_shift[15:0];
                quo_next = {quo_reg[14:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ptach_pkg::DIV_LAST_STEP) begin
                    state_next = ptach_pkg::ST_LOAD;
                end
            end
            ptach_pkg::ST_LOAD: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_period_next = div_reg;
                    m_rpm_next    = (div_reg == '0) ? '0 : quo_reg;
                    state_next    = ptach_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ptach_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ptach_pkg::ST_IDLE;
            phase_reg   <= ptach_pkg::PH_IDLE;
            thr_reg     <= ptach_pkg::THRESHOLD_RESET;
            start_reg   <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            thr_reg     <= thr_next;
            start_reg   <= start_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        div_reg      <= div_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        m_period_reg <= m_period_next;
        m_rpm_reg    <= m_rpm_next;
    end

    // The divider steps its counter once per cycle until the last step.
    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ptach_pkg::ST_DIV) && (cnt_reg != ptach_pkg::DIV_LAST_STEP)
        |=> (state_reg == ptach_pkg::ST_DIV) && (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("divider step counter out of sequence");

    // A new result is only ever loaded from the load state.
    a_load_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ptach_pkg::ST_LOAD))
        else $error("result loaded outside the load state");

    // A zero period always reports zero rpm.
    a_zero_period: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_period_reg == '0) |-> (m_rpm_reg == '0))
        else $error("nonzero rpm for zero period");

    // The quotient of 60000 never exceeds 60000.
    a_rpm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_rpm_reg <= ptach_pkg::MS_PER_MINUTE))
        else $error("rpm above 60000");

    // No sample is taken while the divider runs.
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ptach_pkg::ST_DIV) |=> (phase_reg == $past(phase_reg)))
        else $error("phase changed during a divide");

endmodule

`default_nettype wire
